// File: src/assert_macros.svh
// Assertion macros shared by the breathing duty generator RTL.
// Expects i_clk and i_rst_n in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define PBD_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PBD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/pbd_pkg.sv
// Package for the breathing duty generator: widths, constants, codes and types.
// No dependencies.
`timescale 1ns / 1ps

package pbd_pkg;

    localparam int NOW_W      = 32;
    localparam int REG_W      = 16;
    localparam int CMP_W      = 17;
    localparam int DUTY_W     = 7;
    localparam int CFG_IDX_W  = 1;

    localparam int FRACTION_BITS_DEF = 16;

    localparam logic [REG_W-1:0]  PERIOD_RST   = 16'd3000;
    localparam logic [REG_W-1:0]  RELOAD_RST   = 16'd999;
    localparam logic [NOW_W-1:0]  MIN_INTERVAL = 32'd10;
    localparam logic [DUTY_W-1:0] DUTY_MAX     = 7'd100;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BREATH_PERIOD = 1'b0,
        CFG_TIMER_RELOAD  = 1'b1
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MOD,
        ST_MOD_WAIT,
        ST_TRI,
        ST_TRI_WAIT,
        ST_SQ,
        ST_CMP,
        ST_PCT,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_sts;

endpackage

// File: src/pbd_req_if.sv
// Request channel carrying the millisecond tick.
// Depends on pbd_pkg.
`timescale 1ns / 1ps

interface pbd_req_if import pbd_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [NOW_W-1:0] now_ms;

    modport source (output valid, output now_ms, input ready);
    modport sink   (input valid, input now_ms, output ready);
endinterface

// File: src/pbd_rsp_if.sv
// Result channel carrying the compare value and duty percent.
// Depends on pbd_pkg.
`timescale 1ns / 1ps

interface pbd_rsp_if import pbd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CMP_W-1:0]  compare_value;
    logic [DUTY_W-1:0] duty_pct;

    modport source (output valid, output compare_value, output duty_pct, input ready);
    modport sink   (input valid, input compare_value, input duty_pct, output ready);
endinterface

// File: src/pbd_div.sv
// Shared restoring divider, one quotient bit per cycle, 16-bit divisor.
// Depends on pbd_pkg.
`timescale 1ns / 1ps

module pbd_div import pbd_pkg::*; #(
    parameter int DW = 33
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DW-1:0]    i_dividend,
    input  logic [REG_W-1:0] i_divisor,
    output t_div_sts         o_sts,
    output logic [DW-1:0]    o_quot,
    output logic [REG_W-1:0] o_rem
);

    localparam int CW = $clog2(DW + 1);

    logic             r_busy;
    logic             r_done;
    logic [CW-1:0]    r_cnt;
    logic [DW-1:0]    r_quot;
    logic [REG_W-1:0] r_rem;
    logic [REG_W-1:0] r_div;

    logic [REG_W:0] rem_sh;
    logic [REG_W:0] diff;
    logic           ge;

    assign rem_sh = {r_rem, r_quot[DW-1]};
    assign diff   = rem_sh - {1'b0, r_div};
    assign ge     = (rem_sh >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // dividend shifts out the top of r_quot while quotient bits enter below
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_dividend;
            r_rem  <= '0;
            r_div  <= i_divisor;
        end else if (r_busy) begin
            r_rem  <= ge ? diff[REG_W-1:0] : rem_sh[REG_W-1:0];
            r_quot <= {r_quot[DW-2:0], ge};
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_quot     = r_quot;
    assign o_rem      = r_rem;

endmodule

// File: src/pbd_mul.sv
// Shared unsigned multiplier with registered product and load enable.
// Depends on pbd_pkg.
`timescale 1ns / 1ps

module pbd_mul import pbd_pkg::*; #(
    parameter int AW = 17,
    parameter int BW = 17
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [AW-1:0]    i_a,
    input  logic [BW-1:0]    i_b,
    output logic [AW+BW-1:0] o_p
);

    logic [AW+BW-1:0] r_p;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= (AW+BW)'(i_a) * (AW+BW)'(i_b);
        end
    end

    assign o_p = r_p;

endmodule

// File: src/pwm_breathing_duty_generator.sv
// Breathing PWM duty generator: triangle progress, square-law gamma, compare + percent.
// Ticks without an update are accepted in idle and give no result. An update runs the
// bit-serial divider (DW = max(33, 16 + FRACTION_BITS) bits) for the modulo and, unless
// the half-period is zero, once more for the progress. Ready only while idle.
// Synchronous active-low reset: period 3000, reload 999, tick/elapsed/duty cleared.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pwm_breathing_duty_generator import pbd_pkg::*; #(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    pbd_req_if.sink              i_req,
    pbd_rsp_if.source            o_rsp,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [REG_W-1:0]     i_cfg_wdata
);

    localparam int F  = FRACTION_BITS;
    localparam int DW = (REG_W + F > NOW_W + 1) ? REG_W + F : NOW_W + 1;
    localparam int MA = F + 1;
    localparam int MB = (F + 1 > CMP_W) ? F + 1 : CMP_W;
    localparam int PW = MA + MB;
    localparam logic [F:0]    ONE        = (F+1)'(1) << F;
    localparam logic [PW-1:0] HALF_LSB   = PW'(1) << (F - 1);
    localparam logic [MB-1:0] PCT_SCALE  = MB'(100);

    t_state r_state, n_state;

    logic [REG_W-1:0]  r_period;
    logic [REG_W-1:0]  r_reload;
    logic [NOW_W-1:0]  r_last;
    logic [NOW_W-1:0]  r_dt;
    logic [REG_W-1:0]  r_elapsed;
    logic              r_fall;
    logic [F:0]        r_p;
    logic [F:0]        r_gamma;
    logic [CMP_W-1:0]  r_cmp;
    logic              r_ov;
    logic [CMP_W-1:0]  r_out_cmp;
    logic [DUTY_W-1:0] r_stored_duty;

    logic              in_acc;
    logic              upd_ok;
    logic [NOW_W-1:0]  dt;
    logic [REG_W-1:0]  half;
    logic              tri_fall;
    logic [REG_W-1:0]  tri_num;
    logic [NOW_W:0]    sum_e;
    logic              out_load;

    logic              div_start;
    logic [DW-1:0]     div_dividend;
    logic [REG_W-1:0]  div_divisor;
    t_div_sts          div_sts;
    logic [DW-1:0]     div_quot;
    logic [REG_W-1:0]  div_rem;

    logic              mul_en;
    logic [MA-1:0]     mul_a;
    logic [MB-1:0]     mul_b;
    logic [PW-1:0]     mul_p;

    logic [F:0]        gamma;
    logic [PW-1:0]     pct_sum;
    logic [DUTY_W-1:0] pct_raw;
    logic [DUTY_W-1:0] pct;

    assign in_acc   = i_req.valid && i_req.ready;
    assign dt       = i_req.now_ms - r_last;
    assign upd_ok   = (r_period != '0) && (dt >= MIN_INTERVAL);
    assign half     = {1'b0, r_period[REG_W-1:1]};
    assign tri_fall = (r_elapsed >= half);
    assign tri_num  = tri_fall ? (r_elapsed - half) : r_elapsed;
    assign sum_e    = {{(NOW_W+1-REG_W){1'b0}}, r_elapsed} + {1'b0, r_dt};
    assign gamma    = mul_p[2*F:F];
    assign pct_sum  = mul_p + HALF_LSB;
    assign pct_raw  = pct_sum[F+DUTY_W-1:F];
    assign pct      = (pct_raw > DUTY_MAX) ? DUTY_MAX : pct_raw;

    pbd_div #(.DW(DW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_sts      (div_sts),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    pbd_mul #(.AW(MA), .BW(MB)) u_mul (
        .i_clk (i_clk),
        .i_en  (mul_en),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        i_req.ready  = 1'b0;
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = r_period;
        mul_en       = 1'b0;
        mul_a        = '0;
        mul_b        = '0;
        out_load     = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                i_req.ready = 1'b1;
                if (i_req.valid && upd_ok) begin
                    n_state = ST_MOD;
                end
            end
            ST_MOD: begin
                div_start    = 1'b1;
                div_dividend = DW'(sum_e);
                n_state      = ST_MOD_WAIT;
            end
            ST_MOD_WAIT: begin
                if (div_sts.done) begin
                    n_state = ST_TRI;
                end
            end
            ST_TRI: begin
                // period of 1 ms: zero half-period, progress is zero
                if (half == '0) begin
                    n_state = ST_SQ;
                end else begin
                    div_start    = 1'b1;
                    div_dividend = DW'(tri_num) << F;
                    div_divisor  = half;
                    n_state      = ST_TRI_WAIT;
                end
            end
            ST_TRI_WAIT: begin
                if (div_sts.done) begin
                    n_state = ST_SQ;
                end
            end
            ST_SQ: begin
                mul_en  = 1'b1;
                mul_a   = r_p;
                mul_b   = MB'(r_p);
                n_state = ST_CMP;
            end
            ST_CMP: begin
                mul_en  = 1'b1;
                mul_a   = gamma;
                mul_b   = MB'(r_reload) + MB'(1);
                n_state = ST_PCT;
            end
            ST_PCT: begin
                mul_en  = 1'b1;
                mul_a   = r_gamma;
                mul_b   = PCT_SCALE;
                n_state = ST_FIN;
            end
            ST_FIN: begin
                if (!r_ov || o_rsp.ready) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // config and state registers with reset values
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period      <= PERIOD_RST;
            r_reload      <= RELOAD_RST;
            r_last        <= '0;
            r_elapsed     <= '0;
            r_stored_duty <= '0;
            r_ov          <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_BREATH_PERIOD: r_period <= i_cfg_wdata;
                    CFG_TIMER_RELOAD:  r_reload <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (in_acc && upd_ok) begin
                r_last <= i_req.now_ms;
            end
            if (r_state == ST_MOD_WAIT && div_sts.done) begin
                r_elapsed <= div_rem;
            end
            if (out_load) begin
                r_stored_duty <= pct;
                r_ov          <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_dt <= dt;
        end
        if (r_state == ST_TRI) begin
            r_fall <= tri_fall;
            if (half == '0) begin
                r_p <= '0;
            end
        end
        if (r_state == ST_TRI_WAIT && div_sts.done) begin
            r_p <= r_fall ? (ONE - div_quot[F:0]) : div_quot[F:0];
        end
        if (r_state == ST_CMP) begin
            r_gamma <= gamma;
        end
        if (r_state == ST_PCT) begin
            r_cmp <= mul_p[F+CMP_W-1:F];
        end
        if (out_load) begin
            r_out_cmp <= r_cmp;
        end
    end

    assign o_rsp.valid         = r_ov;
    assign o_rsp.compare_value = r_out_cmp;
    assign o_rsp.duty_pct      = r_stored_duty;

    `PBD_ASSERT_SAME(a_div_free_on_start, div_start, !div_sts.busy, "divider restarted while busy")
    `PBD_ASSERT_NEXT(a_update_starts_mod, in_acc && upd_ok, r_state == ST_MOD, "update not started")
    `PBD_ASSERT_SAME(a_elapsed_in_range, r_state == ST_TRI, r_elapsed < r_period, "elapsed out of period")
    `PBD_ASSERT_SAME(a_duty_max, o_rsp.valid, o_rsp.duty_pct <= DUTY_MAX, "duty above 100")

endmodule

// File: dv/pwm_breathing_duty_generator_tb.sv
// Testbench for pwm_breathing_duty_generator: directed ticks, then randomized phases.
// TICK results are scored against an in-bench duty predictor, FIXED rows against hand-worked values.
// Depends on pbd_pkg, pbd_req_if, pbd_rsp_if and the generator RTL.
`timescale 1ns / 1ps

module pwm_breathing_duty_generator_tb;
    import pbd_pkg::*;

    localparam int          FRAC          = FRACTION_BITS_DEF;
    localparam logic [63:0] FRAC_ONE      = 64'd1 << FRAC;
    localparam int          SETTLE_CYCLES = 100;
    localparam int          HOLD_CYCLES   = 600;
    localparam int          CYCLE_LIMIT   = 1_000_000;
    localparam int          PLAN_LEN      = 24;

    typedef struct packed {
        logic [CMP_W-1:0]  cmp;
        logic [DUTY_W-1:0] pct;
    } t_duty;

    typedef enum {ROW_CFG, ROW_TICK, ROW_FIXED} t_row_kind;

    typedef struct {
        t_row_kind         kind;
        t_cfg_idx          idx;
        logic [REG_W-1:0]  data;
        logic [NOW_W-1:0]  now;
        bit                has_rsp;
        logic [CMP_W-1:0]  cmp;
        logic [DUTY_W-1:0] pct;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [REG_W-1:0]     i_cfg_wdata;

    pbd_req_if req_if ();
    pbd_rsp_if rsp_if ();

    // predictor state and register shadow
    logic [NOW_W-1:0] trk_last_tick;
    logic [REG_W-1:0] trk_phase_ms;
    logic [REG_W-1:0] cfg_period;
    logic [REG_W-1:0] cfg_reload;

    t_duty duty_q[$];
    int    mismatch_cnt = 0;
    int    cycle_cnt = 0;
    bit    hold_rsp = 1'b0;
    bit    sender_steady = 1'b0;

    // FIXED rows carry hand-worked results; TICK rows go through the predictor
    t_row plan [PLAN_LEN] = '{
        '{ROW_FIXED, CFG_BREATH_PERIOD, 16'd0,     32'd0,          1'b0, 17'd0,     7'd0},
        '{ROW_FIXED, CFG_BREATH_PERIOD, 16'd0,     32'd9,          1'b0, 17'd0,     7'd0},
        '{ROW_TICK,  CFG_BREATH_PERIOD, 16'd0,     32'd10,         1'b0, 17'd0,     7'd0},
        '{ROW_FIXED, CFG_BREATH_PERIOD, 16'd0,     32'd19,         1'b0, 17'd0,     7'd0},
        '{ROW_FIXED, CFG_BREATH_PERIOD, 16'd0,     32'd1500,       1'b1, 17'd1000,  7'd100},
        '{ROW_CFG,   CFG_TIMER_RELOAD,  16'd65535, 32'd0,          1'b0, 17'd0,     7'd0},
        '{ROW_FIXED, CFG_BREATH_PERIOD, 16'd0,     32'd4500,       1'b1, 17'd65536, 7'd100},
        '{ROW_CFG,   CFG_TIMER_RELOAD,  16'd0,     32'd0,          1'b0, 17'd0,     7'd0},
        '{ROW_FIXED, CFG_BREATH_PERIOD, 16'd0,     32'd7500,       1'b1, 17'd1,     7'd100},
        '{ROW_FIXED, CFG_BREATH_PERIOD, 16'd0,     32'd9000,       1'b1, 17'd0,     7'd0},
        '{ROW_TICK,  CFG_BREATH_PERIOD, 16'd0,     32'd9750,       1'b0, 17'd0,     7'd0},
        '{ROW_CFG,   CFG_BREATH_PERIOD, 16'd1,     32'd0,          1'b0, 17'd0,     7'd0},
        '{ROW_FIXED, CFG_BREATH_PERIOD, 16'd0,     32'd9800,       1'b1, 17'd0,     7'd0},
        '{ROW_CFG,   CFG_BREATH_PERIOD, 16'd0,     32'd0,          1'b0, 17'd0,     7'd0},
        '{ROW_FIXED, CFG_BREATH_PERIOD, 16'd0,     32'd20000,      1'b0, 17'd0,     7'd0},
        '{ROW_FIXED, CFG_BREATH_PERIOD, 16'd0,     32'hFFFF_FFFF,  1'b0, 17'd0,     7'd0},
        '{ROW_CFG,   CFG_BREATH_PERIOD, 16'd65535, 32'd0,          1'b0, 17'd0,     7'd0},
        '{ROW_CFG,   CFG_TIMER_RELOAD,  16'd999,   32'd0,          1'b0, 17'd0,     7'd0},
        '{ROW_TICK,  CFG_BREATH_PERIOD, 16'd0,     32'd60000,      1'b0, 17'd0,     7'd0},
        // tick steps back 16 ms: interval wraps to nearly 2^32
        '{ROW_TICK,  CFG_BREATH_PERIOD, 16'd0,     32'd59984,      1'b0, 17'd0,     7'd0},
        '{ROW_TICK,  CFG_BREATH_PERIOD, 16'd0,     32'hFFFF_FFFF,  1'b0, 17'd0,     7'd0},
        // shorter period with elapsed time left over from the long one
        '{ROW_CFG,   CFG_BREATH_PERIOD, 16'd3000,  32'd0,          1'b0, 17'd0,     7'd0},
        '{ROW_TICK,  CFG_BREATH_PERIOD, 16'd0,     32'd9,          1'b0, 17'd0,     7'd0},
        '{ROW_TICK,  CFG_BREATH_PERIOD, 16'd0,     32'd3009,       1'b0, 17'd0,     7'd0}
    };

    pwm_breathing_duty_generator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_if),
        .o_rsp       (rsp_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("pwm_breathing_duty_generator test failed");
            $finish;
        end
    end

    // Returns 1 and the new duty when the tick triggers an update.
    function automatic bit breath_update(input logic [NOW_W-1:0] t, output t_duty d);
        logic [NOW_W-1:0] dt;
        logic [63:0]      pos, half, prog, gam, pct;
        d = '0;
        if (cfg_period == '0)
            return 1'b0;
        dt = t - trk_last_tick;
        if (dt < MIN_INTERVAL)
            return 1'b0;
        trk_last_tick = t;
        // exact sum, no wrap, before the modulo
        pos = (64'(trk_phase_ms) + 64'(dt)) % 64'(cfg_period);
        trk_phase_ms = pos[REG_W-1:0];
        half = 64'(cfg_period) >> 1;
        if (half == 64'd0)
            prog = 64'd0;
        else if (pos < half)
            prog = (pos << FRAC) / half;
        else
            prog = FRAC_ONE - (((pos - half) << FRAC) / half);
        gam = (prog * prog) >> FRAC;
        d.cmp = CMP_W'(((64'(cfg_reload) + 64'd1) * gam) >> FRAC);
        pct = (gam * 64'd100 + (64'd1 << (FRAC - 1))) >> FRAC;
        if (pct > 64'(DUTY_MAX))
            pct = 64'(DUTY_MAX);
        d.pct = DUTY_W'(pct);
        return 1'b1;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 20);
        return $urandom_range(40, 120);
    endfunction

    // Next tick: mostly valid intervals, some too-short ones and some wild values.
    function automatic logic [NOW_W-1:0] pick_now();
        int          r;
        logic [31:0] inc;
        r = $urandom_range(0, 99);
        if (r < 45)
            inc = $urandom_range(10, 10 + int'(cfg_period));
        else if (r < 60)
            inc = MIN_INTERVAL;
        else if (r < 70)
            inc = $urandom_range(10, 100);
        else if (r < 78)
            inc = $urandom;
        else if (r < 90)
            inc = $urandom_range(0, 9);
        else
            return $urandom;
        return trk_last_tick + inc;
    endfunction

    function automatic void flag_error(input string msg);
        if (mismatch_cnt < 10)
            $display("[%0t] mismatch: %s", $realtime, msg);
        mismatch_cnt++;
    endfunction

    task automatic offer_tick(input logic [NOW_W-1:0] t);
        req_if.valid  <= 1'b1;
        req_if.now_ms <= t;
        @(posedge i_clk);
        while (!req_if.ready)
            @(posedge i_clk);
    endtask

    task automatic pause_sender(input int n);
        if (n > 0) begin
            req_if.valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // wait until all results are in and the block has gone quiet
    task automatic drain();
        req_if.valid <= 1'b0;
        while (duty_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [REG_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_BREATH_PERIOD: cfg_period = val;
            CFG_TIMER_RELOAD:  cfg_reload = val;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic random_tick();
        logic [NOW_W-1:0] t;
        t_duty            d;
        t = pick_now();
        offer_tick(t);
        if (breath_update(t, d))
            duty_q.push_back(d);
        pause_sender(sender_steady ? 0 : idle_len());
    endtask

    // result side: random stalls, with one long hold-off on request
    initial begin
        int run, stall;
        rsp_if.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 30);
            rsp_if.ready <= 1'b1;
            repeat (run) @(posedge i_clk);
            if (hold_rsp) begin
                stall = HOLD_CYCLES;
                hold_rsp = 1'b0;
            end else begin
                stall = idle_len();
            end
            if (stall > 0) begin
                rsp_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        t_duty want;
        if (i_rst_n === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
            if (duty_q.size() == 0) begin
                flag_error($sformatf("unexpected request result cmp=%0d pct=%0d",
                                     rsp_if.compare_value, rsp_if.duty_pct));
            end else begin
                want = duty_q.pop_front();
                if (rsp_if.compare_value !== want.cmp)
                    flag_error($sformatf("compare_value exp=%0d act=%0d",
                                         want.cmp, rsp_if.compare_value));
                if (rsp_if.duty_pct !== want.pct)
                    flag_error($sformatf("duty_pct exp=%0d act=%0d",
                                         want.pct, rsp_if.duty_pct));
            end
        end
    end

    initial begin
        t_duty            d;
        logic [REG_W-1:0] per, rel;
        int               n;

        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= CFG_BREATH_PERIOD;
        i_cfg_wdata   <= '0;
        req_if.valid  <= 1'b0;
        req_if.now_ms <= '0;
        cfg_period    = PERIOD_RST;
        cfg_reload    = RELOAD_RST;
        trk_last_tick = '0;
        trk_phase_ms  = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part
        for (int i = 0; i < PLAN_LEN; i++) begin
            if (plan[i].kind == ROW_CFG) begin
                drain();
                write_reg(plan[i].idx, plan[i].data);
            end else begin
                offer_tick(plan[i].now);
                if (plan[i].kind == ROW_TICK) begin
                    if (breath_update(plan[i].now, d))
                        duty_q.push_back(d);
                end else begin
                    void'(breath_update(plan[i].now, d));
                    if (plan[i].has_rsp)
                        duty_q.push_back('{cmp: plan[i].cmp, pct: plan[i].pct});
                end
                pause_sender(idle_len());
            end
        end

        // random phases, each under its own register setting
        for (int ph = 0; ph < 8; ph++) begin
            n = 75;
            case (ph)
                0: begin per = 16'($urandom_range(2, 64));   rel = 16'($urandom); end
                1: begin per = 16'd1;                         rel = 16'd65535; n = 20; end
                2: begin per = 16'($urandom);                 rel = 16'd0; end
                3: begin per = 16'd0;                         rel = 16'($urandom); n = 15; end
                4: begin per = 16'd65535;                     rel = 16'd65535; end
                5: begin per = 16'($urandom_range(2, 400));  rel = 16'($urandom); end
                6: begin per = PERIOD_RST;                    rel = RELOAD_RST; end
                default: begin
                    per = 16'($urandom_range(1, 200)) | 16'd1;
                    rel = 16'($urandom);
                end
            endcase
            drain();
            write_reg(CFG_BREATH_PERIOD, per);
            write_reg(CFG_TIMER_RELOAD, rel);
            sender_steady = (ph == 6);
            // long result hold-off while ticks keep coming
            if (ph == 2)
                hold_rsp = 1'b1;
            repeat (n) random_tick();
        end

        drain();
        if (mismatch_cnt == 0 && duty_q.size() == 0)
            $display("pwm_breathing_duty_generator test passed");
        else
            $display("pwm_breathing_duty_generator test failed");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+src
src/pbd_pkg.sv
src/pbd_req_if.sv
src/pbd_rsp_if.sv
src/pbd_div.sv
src/pbd_mul.sv
src/pwm_breathing_duty_generator.sv
dv/pwm_breathing_duty_generator_tb.sv
